// ===== hdl/pstt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled tick timebase package
// Widths, operation codes, sequencer states, divider request and response
// types, and the saturation helpers shared by the timebase modules.
// ----------------------------------------------------------------------------
package pstt_pkg;

    localparam int TIME_W = 63;
    localparam int TIC_W  = 32;

    // Shared divider geometry. The dividend register must hold an elapsed
    // time as well as a full rescale product.
    localparam int DVD_W  = 2 * TIC_W;
    localparam int DIVR_W = TIC_W + 1;
    localparam int REM_W  = DIVR_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    // Numerator of the scale rounding: base * 2^17 + scale.
    localparam int NUM_W  = TIC_W + 18;
    localparam int SCALE_SHIFT = 17;

    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_PAUSE     = 3'd1,
        OP_RESUME    = 3'd2,
        OP_TOGGLE    = 3'd3,
        OP_SET_SIZE  = 3'd4,
        OP_SET_SCALE = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCALE_GO,
        ST_SCALE,
        ST_REB_GO,
        ST_REBASE,
        ST_RSC_GO,
        ST_RESCALE,
        ST_APPLY,
        ST_READ_GO,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  rem_init;
        logic [DVD_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
        logic [CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
        logic [REM_W-1:0]  remainder;
    } t_div_rsp;

    // Tic size limits: zero becomes one, anything wider saturates.
    function automatic logic [TIC_W-1:0] sat_tic(input logic [DVD_W-1:0] q);
        logic [TIC_W-1:0] res;
        if (q == '0) begin
            res = TIC_W'(1);
        end else if (|q[DVD_W-1:TIC_W]) begin
            res = '1;
        end else begin
            res = q[TIC_W-1:0];
        end
        return res;
    endfunction

    // Tic count plus a quotient, saturating at the largest time value.
    function automatic logic [TIME_W-1:0] sat_add_time(input logic [TIME_W-1:0] a,
                                                       input logic [DVD_W-1:0]  b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b[TIME_W-1:0]};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

endpackage

// ===== hdl/pstt_evt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timebase event channel
// Valid/ready channel that carries one operation and its anchor time.
// ----------------------------------------------------------------------------
interface pstt_evt_if import pstt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic [TIME_W-1:0] anchor_now;
    logic [TIC_W-1:0]  new_tic_size;
    logic [TIC_W-1:0]  scale_fixed;

    modport source (output valid, output operation, output anchor_now,
                    output new_tic_size, output scale_fixed, input ready);
    modport sink   (input valid, input operation, input anchor_now,
                    input new_tic_size, input scale_fixed, output ready);

endinterface

// ===== hdl/pstt_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timebase result channel
// Valid/ready channel that carries the reading after one operation.
// ----------------------------------------------------------------------------
interface pstt_res_if import pstt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_tics;
    logic              paused;
    logic [TIC_W-1:0]  tic_size_now;
    logic              rejected;

    modport source (output valid, output now_tics, output paused,
                    output tic_size_now, output rejected, input ready);
    modport sink   (input valid, input now_tics, input paused,
                    input tic_size_now, input rejected, output ready);

endinterface

// ===== hdl/pstt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle. The remainder can be preloaded so that a
// division whose quotient is known to be short skips the leading steps.
// ----------------------------------------------------------------------------
module pstt_div import pstt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [REM_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVD_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_divisor;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [REM_W:0]    w_rem_sh;
    logic              w_ge;
    logic [REM_W:0]    w_diff;

    assign w_rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_divisor};
    assign w_diff   = w_rem_sh - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem     <= i_req.rem_init;
                r_dvd     <= i_req.dividend;
                r_divisor <= i_req.divisor;
                r_quo     <= '0;
                r_cnt     <= i_req.steps;
            end else if (r_cnt != '0) begin
                r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                r_quo  <= {r_quo[DVD_W-2:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== hdl/pausable_scaled_tick_timebase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pausable scaled tick timebase
// Turns an external anchor time into a tic reading that can be paused,
// resumed and re-rated without jumping, using one shared serial divider.
// ----------------------------------------------------------------------------
// Each event transaction carries an operation and the current anchor time;
// exactly one result transaction follows it. The block takes one event at a
// time, and the shared divider yields one quotient bit per cycle. A plain
// read while running needs one 63-step division of the elapsed time. Any
// read while paused, and a refused size or scale while paused, needs no
// division. Pause and resume each need one such division. Setting a tic
// size while running rebases (63 steps) and rescales the partial tic
// (32 steps); setting a scale first computes the new size (50 steps).
// While paused the rebase is skipped. The next event can be taken while a
// finished result still waits on the output register. The base tic size
// register must be written through the configuration port only while no
// event is in progress; the block itself does not enforce this. Writing it
// also loads the tic size in force.
// ----------------------------------------------------------------------------
module pausable_scaled_tick_timebase import pstt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TIC_W-1:0] i_cfg_wr_data,
    pstt_evt_if.sink         i_evt,
    pstt_res_if.source       o_res
);

    // Architectural state of the timeline.
    logic [TIME_W-1:0] r_banked;
    logic [TIME_W-1:0] r_origin;
    logic              r_paused;
    logic [TIC_W-1:0]  r_held;
    logic [TIC_W-1:0]  r_cur;
    logic [TIC_W-1:0]  r_base;

    // The event in progress.
    logic [2:0]        r_op;
    logic [TIME_W-1:0] r_now;
    logic [TIC_W-1:0]  r_target;
    logic [TIC_W-1:0]  r_scale;

    // Working values of the sequencer.
    logic [TIC_W-1:0]  r_rem;
    logic [TIC_W-1:0]  r_resc;
    logic [TIME_W-1:0] r_reading;
    logic              r_rd_valid;
    logic              r_rej;

    // Output register.
    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_tics;
    logic              r_out_paused;
    logic [TIC_W-1:0]  r_out_size;
    logic              r_out_rej;

    t_state            r_state;
    t_state            n_state;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    logic              w_rej;
    logic              w_set_scale;
    logic              w_set_size;
    logic              w_pause;
    logic              w_resume;
    logic              w_rate_op;
    logic              w_rsc_trivial;
    logic [TIC_W-1:0]  w_rsc_trivial_val;
    logic              w_out_load;
    logic [TIME_W-1:0] w_elapsed;
    logic [NUM_W-1:0]  w_num;
    logic [DVD_W-1:0]  w_prod;

    // ------------------------------------------------------------------
    // Decode of the event held in r_op. The pause and resume cases are
    // exclusive because they depend on the paused flag; a pause while
    // paused or a resume while running falls through to a plain read.
    // ------------------------------------------------------------------
    always_comb begin
        w_rej       = ((r_op == OP_SET_SIZE)  && (r_target == '0)) ||
                      ((r_op == OP_SET_SCALE) && (r_scale == '0));
        w_set_size  = (r_op == OP_SET_SIZE)  && (r_target != '0);
        w_set_scale = (r_op == OP_SET_SCALE) && (r_scale != '0);
        w_pause     = ((r_op == OP_PAUSE) || (r_op == OP_TOGGLE)) && !r_paused;
        w_resume    = ((r_op == OP_RESUME) || (r_op == OP_TOGGLE)) && r_paused;
        w_rate_op   = (r_op == OP_SET_SIZE) || (r_op == OP_SET_SCALE);
    end

    // Elapsed anchor time wraps modulo the time width, as does the origin.
    assign w_elapsed = r_now - r_origin;
    assign w_num     = (NUM_W'(r_base) << SCALE_SHIFT) + NUM_W'(r_scale);

    // Partial tic product; it is loaded straight into the divider registers.
    assign w_prod    = DVD_W'(r_rem) * DVD_W'(r_target);

    // A partial tic needs no division when it is zero or the size does not
    // change. A partial tic of at least one old tic (possible after the base
    // size was rewritten while paused) clamps to one below the new size.
    always_comb begin
        w_rsc_trivial     = (r_rem == '0) || (r_cur == r_target) || (r_rem >= r_cur);
        w_rsc_trivial_val = ((r_rem == '0) || (r_cur == r_target)) ?
                            r_rem : (r_target - TIC_W'(1));
    end

    // The result leaves the sequencer once the output register is free.
    assign w_out_load = (r_state == ST_FINISH) && (!r_out_valid || o_res.ready);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_evt.valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (w_set_scale) begin
                    n_state = ST_SCALE_GO;
                end else if (w_set_size) begin
                    n_state = r_paused ? ST_RSC_GO : ST_REB_GO;
                end else if (w_pause) begin
                    n_state = ST_REB_GO;
                end else if (w_resume) begin
                    n_state = ST_READ_GO;
                end else begin
                    // Reads, no-op pauses and resumes, and refused changes.
                    n_state = r_paused ? ST_FINISH : ST_READ_GO;
                end
            end
            ST_SCALE_GO: n_state = ST_SCALE;
            ST_SCALE: begin
                if (w_div_rsp.done) begin
                    n_state = r_paused ? ST_RSC_GO : ST_REB_GO;
                end
            end
            ST_REB_GO: n_state = ST_REBASE;
            ST_REBASE: begin
                if (w_div_rsp.done) begin
                    n_state = w_rate_op ? ST_RSC_GO : ST_FINISH;
                end
            end
            ST_RSC_GO: n_state = w_rsc_trivial ? ST_APPLY : ST_RESCALE;
            ST_RESCALE: begin
                if (w_div_rsp.done) begin
                    n_state = ST_APPLY;
                end
            end
            // After a rate change the partial tic is below one tic, so the
            // reading equals the banked count and needs no division.
            ST_APPLY: n_state = ST_FINISH;
            ST_READ_GO: n_state = ST_READ;
            ST_READ: begin
                if (w_div_rsp.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. The divider is started from the *_GO states.
    // ------------------------------------------------------------------
    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            ST_SCALE_GO: begin
                // Round half up of base / scale in Q16.16.
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {w_num, {(DVD_W - NUM_W){1'b0}}};
                w_div_req.divisor  = {r_scale, 1'b0};
                w_div_req.steps    = CNT_W'(NUM_W);
            end
            ST_REB_GO, ST_READ_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {w_elapsed, {(DVD_W - TIME_W){1'b0}}};
                w_div_req.divisor  = {1'b0, r_cur};
                w_div_req.steps    = CNT_W'(TIME_W);
            end
            ST_RSC_GO: begin
                // The upper half of the product is below the old size, so
                // it serves as the starting remainder of a short division.
                w_div_req.start    = !w_rsc_trivial;
                w_div_req.rem_init = {1'b0, w_prod[DVD_W-1:TIC_W]};
                w_div_req.dividend = {w_prod[TIC_W-1:0], {(DVD_W - TIC_W){1'b0}}};
                w_div_req.divisor  = {1'b0, r_cur};
                w_div_req.steps    = CNT_W'(TIC_W);
            end
            default: w_div_req = '0;
        endcase
    end

    assign i_evt.ready = (r_state == ST_IDLE);

    pstt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Timeline state and working registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banked <= '0;
            r_origin <= '0;
            r_paused <= 1'b0;
            r_held   <= '0;
            r_cur    <= TIC_W'(1);
            r_base   <= TIC_W'(1);
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= (i_cfg_wr_data == '0) ? TIC_W'(1) : i_cfg_wr_data;
                r_cur  <= (i_cfg_wr_data == '0) ? TIC_W'(1) : i_cfg_wr_data;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_evt.valid) begin
                        r_op       <= i_evt.operation;
                        r_now      <= i_evt.anchor_now;
                        r_target   <= i_evt.new_tic_size;
                        r_scale    <= i_evt.scale_fixed;
                        r_rd_valid <= 1'b0;
                        r_rej      <= 1'b0;
                    end
                end
                ST_DISPATCH: begin
                    if (w_rej) begin
                        r_rej <= 1'b1;
                    end
                    if (w_set_size && r_paused) begin
                        r_rem <= r_held;
                    end
                    if (w_resume) begin
                        r_origin <= r_now - TIME_W'(r_held);
                        r_paused <= 1'b0;
                    end
                end
                ST_SCALE: begin
                    if (w_div_rsp.done) begin
                        r_target <= sat_tic(w_div_rsp.quotient);
                        if (r_paused) begin
                            r_rem <= r_held;
                        end
                    end
                end
                ST_REBASE: begin
                    if (w_div_rsp.done) begin
                        r_banked <= sat_add_time(r_banked, w_div_rsp.quotient);
                        r_origin <= r_now - TIME_W'(w_div_rsp.remainder[TIC_W-1:0]);
                        r_rem    <= w_div_rsp.remainder[TIC_W-1:0];
                        if (!w_rate_op) begin
                            r_held   <= w_div_rsp.remainder[TIC_W-1:0];
                            r_paused <= 1'b1;
                        end
                    end
                end
                ST_RSC_GO: begin
                    if (w_rsc_trivial) begin
                        r_resc <= w_rsc_trivial_val;
                    end
                end
                ST_RESCALE: begin
                    if (w_div_rsp.done) begin
                        r_resc <= w_div_rsp.quotient[TIC_W-1:0];
                    end
                end
                ST_APPLY: begin
                    if (r_paused) begin
                        r_held <= r_resc;
                    end else begin
                        r_origin <= r_now - TIME_W'(r_resc);
                    end
                    r_cur <= r_target;
                end
                ST_READ: begin
                    if (w_div_rsp.done) begin
                        r_reading  <= sat_add_time(r_banked, w_div_rsp.quotient);
                        r_rd_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register. A reading that needed no division is the banked
    // count itself.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_tics   <= r_rd_valid ? r_reading : r_banked;
            r_out_paused <= r_paused;
            r_out_size   <= r_cur;
            r_out_rej    <= r_rej;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.now_tics     = r_out_tics;
    assign o_res.paused       = r_out_paused;
    assign o_res.tic_size_now = r_out_size;
    assign o_res.rejected     = r_out_rej;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pausable scaled tick timebase testbench
// Drives event transactions into the timebase and checks every result
// transaction against an in-bench model of the tic timeline. The model covers
// banking, pausing and restating the partial tic. The run starts with directed
// corner cases and then moves through several base tic sizes with random
// event streams and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import pstt_pkg::*;

    // Operation codes 6 and 7 are unused and must behave like a read.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam bit [TIME_W-1:0] TIME_TOP = '1;
    localparam int MAX_WAIT        = 16;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 200;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int BASE_SETTINGS   = 8;

    typedef struct packed {
        bit [2:0]        op;
        bit [TIME_W-1:0] anchor;
        bit [TIC_W-1:0]  size_req;
        bit [TIC_W-1:0]  scale_req;
    } t_timebase_event;

    // The result fields stay four-state so that an X from the block is seen.
    typedef struct packed {
        logic [TIME_W-1:0] tics;
        logic              paused;
        logic [TIC_W-1:0]  tic_size;
        logic              rejected;
    } t_reading;

    // ------------------------------------------------------------------------
    // Timeline model and the queue of readings still owed by the block.
    // ------------------------------------------------------------------------
    class timeline_scoreboard;
        bit [TIME_W-1:0] banked;
        bit [TIME_W-1:0] origin;
        bit              halted;
        bit [TIC_W-1:0]  held_part;
        bit [TIC_W-1:0]  tic_size;
        bit [TIC_W-1:0]  base_size;
        t_reading        readings_due[$];
        int              mismatches;
        int              checked;
        int              refusals;
        int              op_count[8];

        function new();
            banked     = '0;
            origin     = '0;
            halted     = 1'b0;
            held_part  = '0;
            tic_size   = TIC_W'(1);
            base_size  = TIC_W'(1);
            mismatches = 0;
            checked    = 0;
            refusals   = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void load_base(bit [TIC_W-1:0] value);
            base_size = (value == '0) ? TIC_W'(1) : value;
            tic_size  = base_size;
        endfunction

        function bit [TIC_W-1:0] clamp_size(bit [DVD_W-1:0] q);
            if (q == '0) return TIC_W'(1);
            if (q > DVD_W'({TIC_W{1'b1}})) return '1;
            return q[TIC_W-1:0];
        endfunction

        function bit [TIME_W-1:0] add_tics(bit [TIME_W-1:0] a, bit [TIME_W-1:0] b);
            bit [TIME_W:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
        endfunction

        // Same fraction of a tic at the new size, always below one whole tic.
        function bit [TIC_W-1:0] restate(bit [TIC_W-1:0] part, bit [TIC_W-1:0] from,
                                         bit [TIC_W-1:0] to);
            bit [DVD_W-1:0] q;
            if (part == '0 || from == to) return part;
            q = (DVD_W'(part) * DVD_W'(to)) / DVD_W'(from);
            if (q > DVD_W'(to - 1'b1)) return to - 1'b1;
            return q[TIC_W-1:0];
        endfunction

        // Moves the whole tics since the origin into the bank and returns the
        // partial tic that is left over.
        function bit [TIC_W-1:0] bank_whole_tics(bit [TIME_W-1:0] now);
            bit [TIME_W-1:0] elapsed;
            bit [TIC_W-1:0]  part;
            elapsed = now - origin;
            part    = TIC_W'(elapsed % TIME_W'(tic_size));
            banked  = add_tics(banked, elapsed / TIME_W'(tic_size));
            origin  = now - TIME_W'(part);
            return part;
        endfunction

        function void pause_at(bit [TIME_W-1:0] now);
            if (!halted) begin
                held_part = bank_whole_tics(now);
                halted    = 1'b1;
            end
        endfunction

        function void resume_at(bit [TIME_W-1:0] now);
            if (halted) begin
                origin = now - TIME_W'(held_part);
                halted = 1'b0;
            end
        endfunction

        function void change_size(bit [TIME_W-1:0] now, bit [TIC_W-1:0] new_size);
            bit [TIC_W-1:0] part;
            if (halted) begin
                held_part = restate(held_part, tic_size, new_size);
            end else begin
                part   = bank_whole_tics(now);
                origin = now - TIME_W'(restate(part, tic_size, new_size));
            end
            tic_size = new_size;
        endfunction

        function void note_event(t_timebase_event ev);
            t_reading        want;
            bit              refused;
            bit [TIME_W-1:0] elapsed;
            bit [DVD_W-1:0]  numer;
            refused = 1'b0;
            op_count[ev.op]++;
            case (ev.op)
                OP_PAUSE: begin
                    pause_at(ev.anchor);
                end
                OP_RESUME: begin
                    resume_at(ev.anchor);
                end
                OP_TOGGLE: begin
                    if (halted) resume_at(ev.anchor);
                    else pause_at(ev.anchor);
                end
                OP_SET_SIZE: begin
                    if (ev.size_req == '0) refused = 1'b1;
                    else change_size(ev.anchor, clamp_size(DVD_W'(ev.size_req)));
                end
                OP_SET_SCALE: begin
                    if (ev.scale_req == '0) begin
                        refused = 1'b1;
                    end else begin
                        // Twice the base in Q16.16 plus the scale, over twice
                        // the scale: base / scale rounded half up.
                        numer = (DVD_W'(base_size) << 17) + DVD_W'(ev.scale_req);
                        change_size(ev.anchor,
                                    clamp_size(numer / (DVD_W'(ev.scale_req) << 1)));
                    end
                end
                default: begin
                end
            endcase
            if (halted) begin
                want.tics = banked;
            end else begin
                elapsed   = ev.anchor - origin;
                want.tics = add_tics(banked, elapsed / TIME_W'(tic_size));
            end
            want.paused   = halted;
            want.tic_size = tic_size;
            want.rejected = refused;
            if (refused) refusals++;
            readings_due.push_back(want);
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        endtask

        task check_result(t_reading got);
            t_reading want;
            if (readings_due.size() == 0) begin
                report("now_tics of a result nobody asked for", 64'(got.tics), 64'd0);
            end else begin
                want = readings_due.pop_front();
                checked++;
                if (got.tics !== want.tics)
                    report("now_tics", 64'(got.tics), 64'(want.tics));
                if (got.paused !== want.paused)
                    report("paused", 64'(got.paused), 64'(want.paused));
                if (got.tic_size !== want.tic_size)
                    report("tic_size_now", 64'(got.tic_size), 64'(want.tic_size));
                if (got.rejected !== want.rejected)
                    report("rejected", 64'(got.rejected), 64'(want.rejected));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its channels.
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [TIC_W-1:0] cfg_wr_data;

    pstt_evt_if evt_ch ();
    pstt_res_if res_ch ();

    pausable_scaled_tick_timebase i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_evt         (evt_ch.sink),
        .o_res         (res_ch.source)
    );

    timeline_scoreboard sb = new();

    // Anchor time of the well-formed event stream. It only moves forward;
    // stray reads with an arbitrary anchor do not touch it.
    bit [TIME_W-1:0] anchor_track;
    // While set, neither channel idles, so events come back to back.
    bit              quiet_phase;
    int              cycles;
    int              settings_used;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Each side waits a random number of cycles per transaction; about a
    // quarter of the draws and all of a quiet phase give no wait at all.
    function automatic int draw_wait();
        if (quiet_phase || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Result side: stall, then take one result transaction and check it.
    initial begin
        t_reading got;
        int       stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got.tics     = res_ch.now_tics;
            got.paused   = res_ch.paused;
            got.tic_size = res_ch.tic_size_now;
            got.rejected = res_ch.rejected;
            sb.check_result(got);
        end
    end

    // Offers one event transaction and returns at the edge that accepts it.
    // Valid is only lowered when a gap follows, so back-to-back events never
    // see valid dropped and raised in the same time step.
    task automatic send_event(t_timebase_event ev);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.operation    <= ev.op;
        evt_ch.anchor_now   <= ev.anchor;
        evt_ch.new_tic_size <= ev.size_req;
        evt_ch.scale_fixed  <= ev.scale_req;
        do @(posedge clk); while (evt_ch.ready !== 1'b1);
        sb.note_event(ev);
    endtask

    // Holds off the sender until every owed result has come back, so the
    // block is idle and the base register may be written.
    task automatic wait_for_drain();
        evt_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(bit [TIC_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.load_base(value);
        settings_used++;
    endtask

    function automatic t_timebase_event make_event(logic [2:0] op, bit [TIME_W-1:0] anchor,
                                                   bit [TIC_W-1:0] size_req,
                                                   bit [TIC_W-1:0] scale_req);
        t_timebase_event ev;
        ev.op        = op;
        ev.anchor    = anchor;
        ev.size_req  = size_req;
        ev.scale_req = scale_req;
        return ev;
    endfunction

    // One random event. Most anchors step forward by small amounts so that
    // pauses, restated partial tics and rate changes interact; a few make
    // large forward jumps, and a few reads use an arbitrary anchor, which
    // also covers anchors that go backwards.
    function automatic t_timebase_event draw_event();
        t_timebase_event ev;
        int              pick;
        bit [TIME_W-1:0] room;
        bit [TIME_W-1:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 25)      ev.op = OP_READ;
        else if (pick < 31) ev.op = ($urandom_range(0, 1) == 1) ? OP_SPARE_6 : OP_SPARE_7;
        else if (pick < 43) ev.op = OP_PAUSE;
        else if (pick < 55) ev.op = OP_RESUME;
        else if (pick < 65) ev.op = OP_TOGGLE;
        else if (pick < 83) ev.op = OP_SET_SIZE;
        else                ev.op = OP_SET_SCALE;

        room = TIME_TOP - anchor_track;
        pick = $urandom_range(0, 99);
        if (pick < 60)                 step = TIME_W'($urandom_range(0, 300));
        else if (pick < 85)            step = TIME_W'($urandom_range(0, 100000));
        else if (pick < 97)            step = TIME_W'($urandom);
        else if ((room >> 4) == '0)    step = room;
        else                           step = TIME_W'({$urandom, $urandom}) % (room >> 4);
        if (step > room) step = room;
        anchor_track = anchor_track + step;
        ev.anchor    = anchor_track;
        if ((ev.op == OP_READ || ev.op == OP_SPARE_6 || ev.op == OP_SPARE_7) &&
            $urandom_range(0, 24) == 0) begin
            ev.anchor = TIME_W'({$urandom, $urandom});
        end

        pick = $urandom_range(0, 99);
        if (pick < 5)       ev.size_req = '0;
        else if (pick < 55) ev.size_req = $urandom_range(1, 64);
        else if (pick < 80) ev.size_req = $urandom_range(1, 100000);
        else                ev.size_req = $urandom;

        pick = $urandom_range(0, 99);
        if (pick < 5)       ev.scale_req = '0;
        else if (pick < 50) ev.scale_req = $urandom_range(32'h0000_4000, 32'h0004_0000);
        else if (pick < 70) ev.scale_req = $urandom_range(1, 255);
        else                ev.scale_req = $urandom;
        return ev;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_event(draw_event());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        bit [TIC_W-1:0]  base_list [BASE_SETTINGS];
        bit [TIME_W-1:0] a;
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        evt_ch.valid        <= 1'b0;
        evt_ch.operation    <= OP_READ;
        evt_ch.anchor_now   <= '0;
        evt_ch.new_tic_size <= '0;
        evt_ch.scale_fixed  <= '0;
        quiet_phase   = 1'b0;
        anchor_track  = '0;
        settings_used = 0;

        // Zero must load one; the two ends of the range; the rest in between.
        base_list[0] = '0;
        base_list[1] = '1;
        base_list[2] = 1000;
        base_list[3] = 32'h0001_0000;
        base_list[4] = $urandom_range(2, 5000);
        base_list[5] = 7;
        base_list[6] = $urandom;
        base_list[7] = 1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset base size of one. Reads at the origin
        // and with the unused codes, a repeated pause, a partial tic held
        // over a pause and restated to a new size, refused zero size while
        // paused and while running, refused zero scale while paused, a
        // repeated resume, toggling both ways, scales that halve the rate and
        // that collapse the size to its floor, the largest size, and reads at
        // the top of the anchor range and with an anchor that went backwards.
        send_event(make_event(OP_READ,      0,            $urandom, $urandom));
        send_event(make_event(OP_SPARE_6,   150,          $urandom, $urandom));
        send_event(make_event(OP_SPARE_7,   151,          $urandom, $urandom));
        send_event(make_event(OP_SET_SIZE,  180,          5,        $urandom));
        send_event(make_event(OP_PAUSE,     203,          $urandom, $urandom));
        send_event(make_event(OP_PAUSE,     250,          $urandom, $urandom));
        send_event(make_event(OP_SET_SIZE,  310,          0,        $urandom));
        send_event(make_event(OP_SET_SCALE, 320,          $urandom, 0));
        send_event(make_event(OP_SET_SIZE,  330,          7,        $urandom));
        send_event(make_event(OP_RESUME,    400,          $urandom, $urandom));
        send_event(make_event(OP_RESUME,    410,          $urandom, $urandom));
        send_event(make_event(OP_TOGGLE,    500,          $urandom, $urandom));
        send_event(make_event(OP_TOGGLE,    600,          $urandom, $urandom));
        send_event(make_event(OP_SET_SCALE, 700,          $urandom, 32'h0000_8000));
        send_event(make_event(OP_SET_SCALE, 800,          $urandom, 32'hFFFF_FFFF));
        send_event(make_event(OP_SET_SIZE,  900,          '1,       $urandom));
        send_event(make_event(OP_SET_SIZE,  1000,         1,        $urandom));
        send_event(make_event(OP_READ,      TIME_TOP - 5, $urandom, $urandom));
        send_event(make_event(OP_READ,      TIME_TOP,     $urandom, $urandom));
        send_event(make_event(OP_READ,      10,           $urandom, $urandom));
        send_event(make_event(OP_SET_SIZE,  1100,         3,        $urandom));
        send_event(make_event(OP_SET_SIZE,  1150,         0,        $urandom));
        send_event(make_event(OP_PAUSE,     1200,         $urandom, $urandom));
        send_event(make_event(OP_READ,      1300,         $urandom, $urandom));
        anchor_track = 1300;
        run_random(100);

        // One phase per base tic size; every third phase runs without idling.
        for (int i = 0; i < BASE_SETTINGS; i++) begin
            wait_for_drain();
            write_base(base_list[i]);
            quiet_phase = (i % 3 == 2);
            run_random(ITEMS_PER_PHASE);
        end

        // Saturated bank comes last, since the bank never drops again: at a
        // size of one, a pause at an anchor just behind the origin banks a
        // wrapped elapsed time.
        wait_for_drain();
        quiet_phase = 1'b0;
        a = anchor_track;
        send_event(make_event(OP_RESUME,   a,      $urandom, $urandom));
        send_event(make_event(OP_SET_SIZE, a,      1,        $urandom));
        send_event(make_event(OP_PAUSE,    a - 1,  $urandom, $urandom));
        send_event(make_event(OP_READ,     a + 10, $urandom, $urandom));
        send_event(make_event(OP_RESUME,   a + 20, $urandom, $urandom));
        send_event(make_event(OP_READ,     a + 30, $urandom, $urandom));

        // Everything owed must arrive, and nothing more may follow.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d checked results over %0d base tic sizes, %0d refused.",
                 sb.checked, settings_used + 1, sb.refusals);
        $display({"Events: read %0d, unused code %0d, pause %0d, resume %0d, ",
                  "toggle %0d, size %0d, scale %0d."},
                 sb.op_count[OP_READ], sb.op_count[OP_SPARE_6] + sb.op_count[OP_SPARE_7],
                 sb.op_count[OP_PAUSE], sb.op_count[OP_RESUME], sb.op_count[OP_TOGGLE],
                 sb.op_count[OP_SET_SIZE], sb.op_count[OP_SET_SCALE]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
